// ===== rtl/core/stl_pkg.sv =====
package stl_pkg;

  // text buffer depth; a text token holds at most MAX_TEXT-1 characters
  localparam int unsigned MAX_TEXT = 32;
  localparam int unsigned TXT_AW   = $clog2(MAX_TEXT);

  // field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned NUM_W  = 17;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned DIG_W  = 3;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // token limits
  localparam logic [DIG_W-1:0] MAX_DIGITS = 3'd5;
  localparam logic [CNT_W-1:0] TEXT_LIMIT = CNT_W'(MAX_TEXT - 1);
  localparam logic [CNT_W-1:0] TEXT_DEPTH = CNT_W'(MAX_TEXT);

  typedef enum logic [2:0] {
    LEX_IDLE,
    LEX_SKIP,
    LEX_COMMENT,
    LEX_NUMBER,
    LEX_TEXT
  } lex_mode_e;

  typedef enum logic [1:0] {
    PH_READY,
    PH_NUMBER,
    PH_TEXT,
    PH_END
  } emit_phase_e;

endpackage

// ===== rtl/core/stl_ram.sv =====
module stl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/script_token_lexer.sv =====
// A number or end token is loaded into the output register from its emit phase
// once the output is free; a text character first passes a buffer RAM read.
// Bytes with no result are accepted back to back; a byte with results holds the
// input until its results are loaded: the number token, each text character
// after its buffer read, then the end token.
// Reset clears the lexer state and output valid; the text buffer is not cleared.
module script_token_lexer import stl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAR_W-1:0] char_byte_i,
  input  logic              single_char_mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [KIND_W-1:0] token_kind_o,
  output logic [NUM_W-1:0]  number_value_o,
  output logic [CHAR_W-1:0] text_char_o,
  output logic [CNT_W-1:0]  text_index_o,
  output logic [CNT_W-1:0]  text_length_o,
  output logic              last_o
);

  // lexer state
  lex_mode_e         mode_q, mode_d;
  logic [NUM_W-1:0]  accum_q, accum_d;
  logic [DIG_W-1:0]  digits_q, digits_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              latched_q, latched_d;

  // pending results of the accepted item
  logic [NUM_W-1:0]  num_pend_q;
  logic [CNT_W-1:0]  len_pend_q;
  logic              end_pend_q;

  // emit sequencer
  emit_phase_e       phase_q, phase_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  ld_idx_q, ld_idx_d;
  logic              rd_pend_q, rd_pend_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic              last_q, last_d;

  // combinational helpers
  logic              in_acc;
  logic              run_idle;
  logic              is_digit;
  logic [NUM_W-1:0]  digit_val;
  logic [NUM_W-1:0]  acc_next;
  logic [DIG_W-1:0]  digits_next;
  logic [CNT_W-1:0]  count_next;
  logic              p_num;
  logic [NUM_W-1:0]  p_numval;
  logic [CNT_W-1:0]  p_len;
  logic              p_end;
  logic              ram_we;
  logic [TXT_AW-1:0] ram_waddr;
  logic              ram_re;
  logic [CHAR_W-1:0] ram_rdata;
  logic              out_free;
  logic              load;
  logic              txt_load;
  logic              txt_last;
  logic              issue;

  assign in_stall_o = (phase_q != PH_READY);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_digit    = char_byte_i inside {[CH_ZERO:CH_NINE]};
  assign digit_val   = NUM_W'(char_byte_i - CH_ZERO);
  assign acc_next    = NUM_W'({accum_q, 3'b000} + {accum_q, 1'b0} + digit_val);
  assign digits_next = digits_q + 3'd1;
  assign count_next  = count_q + 6'd1;

  // byte classification and lexer state update
  always_comb begin
    mode_d    = mode_q;
    accum_d   = accum_q;
    digits_d  = digits_q;
    count_d   = count_q;
    latched_d = latched_q;
    p_num     = 1'b0;
    p_numval  = accum_q;
    p_len     = '0;
    p_end     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_q[TXT_AW-1:0];
    run_idle  = 1'b0;

    case (mode_q)
      LEX_SKIP: begin
        mode_d = LEX_IDLE;
        if (char_byte_i == CH_NUL) begin
          p_end = 1'b1;
        end
      end
      LEX_COMMENT: begin
        if (char_byte_i == CH_NUL) begin
          mode_d = LEX_IDLE;
          p_end  = 1'b1;
        end else if (char_byte_i == CH_CR) begin
          mode_d = LEX_SKIP;
        end else if (char_byte_i == CH_LF) begin
          mode_d = LEX_IDLE;
        end
      end
      LEX_NUMBER: begin
        if (is_digit) begin
          if (digits_next >= MAX_DIGITS) begin
            p_num    = 1'b1;
            p_numval = acc_next;
            accum_d  = '0;
            digits_d = '0;
            mode_d   = LEX_IDLE;
          end else begin
            accum_d  = acc_next;
            digits_d = digits_next;
          end
        end else begin
          p_num    = 1'b1;
          p_numval = accum_q;
          accum_d  = '0;
          digits_d = '0;
          run_idle = 1'b1;
        end
      end
      LEX_TEXT: begin
        if (char_byte_i inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL}) begin
          p_len    = count_q;
          count_d  = '0;
          run_idle = 1'b1;
        end else if (count_q < TEXT_DEPTH) begin
          ram_we = 1'b1;
          if (count_next >= TEXT_LIMIT || latched_q) begin
            p_len   = count_next;
            count_d = '0;
            mode_d  = LEX_IDLE;
          end else begin
            count_d = count_next;
          end
        end else begin
          p_len   = count_q;
          count_d = '0;
          mode_d  = LEX_IDLE;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // byte seen between tokens
    if (run_idle) begin
      mode_d = LEX_IDLE;
      if (char_byte_i inside {CH_SPACE, CH_TAB, CH_COMMA, CH_LF}) begin
        mode_d = LEX_IDLE;
      end else if (char_byte_i == CH_CR) begin
        mode_d = LEX_SKIP;
      end else if (char_byte_i == CH_HASH) begin
        mode_d = LEX_COMMENT;
      end else if (char_byte_i == CH_NUL) begin
        p_end = 1'b1;
      end else if (is_digit) begin
        accum_d  = digit_val;
        digits_d = 3'd1;
        mode_d   = LEX_NUMBER;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        latched_d = single_char_mode_i;
        if (single_char_mode_i || (TEXT_LIMIT <= 6'd1)) begin
          p_len   = 6'd1;
          count_d = '0;
        end else begin
          count_d = 6'd1;
          mode_d  = LEX_TEXT;
        end
      end
    end
  end

  stl_ram #(
    .Width (CHAR_W),
    .Depth (MAX_TEXT)
  ) u_text_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we && in_acc),
    .waddr_i (ram_waddr),
    .wdata_i (char_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[TXT_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign txt_last = ((ld_idx_q + 6'd1) == len_pend_q);

  // emit sequencer: number, then text run, then end token
  always_comb begin
    phase_d   = phase_q;
    rd_idx_d  = rd_idx_q;
    ld_idx_d  = ld_idx_q;
    rd_pend_d = rd_pend_q;
    ram_re    = 1'b0;
    load      = 1'b0;
    txt_load  = 1'b0;
    issue     = 1'b0;
    kind_d    = kind_q;
    num_d     = num_q;
    char_d    = char_q;
    idx_d     = idx_q;
    len_d     = len_q;
    last_d    = last_q;

    case (phase_q)
      PH_READY: begin
        if (in_acc) begin
          rd_idx_d  = '0;
          rd_pend_d = 1'b0;
          if (p_num) begin
            phase_d = PH_NUMBER;
          end else if (p_len != '0) begin
            phase_d = PH_TEXT;
          end else if (p_end) begin
            phase_d = PH_END;
          end
        end
      end
      PH_NUMBER: begin
        if (out_free) begin
          load   = 1'b1;
          kind_d = KIND_NUMBER;
          num_d  = num_pend_q;
          char_d = '0;
          idx_d  = '0;
          len_d  = '0;
          last_d = 1'b1;
          if (len_pend_q != '0) begin
            phase_d = PH_TEXT;
          end else if (end_pend_q) begin
            phase_d = PH_END;
          end else begin
            phase_d = PH_READY;
          end
        end
      end
      PH_TEXT: begin
        txt_load = rd_pend_q && out_free;
        issue    = (rd_idx_q < len_pend_q) && (!rd_pend_q || txt_load);
        if (txt_load) begin
          load   = 1'b1;
          kind_d = KIND_TEXT;
          num_d  = '0;
          char_d = ram_rdata;
          idx_d  = ld_idx_q;
          len_d  = len_pend_q;
          last_d = txt_last;
          if (txt_last) begin
            phase_d = end_pend_q ? PH_END : PH_READY;
          end
        end
        if (issue) begin
          ram_re    = 1'b1;
          ld_idx_d  = rd_idx_q;
          rd_idx_d  = rd_idx_q + 6'd1;
          rd_pend_d = 1'b1;
        end else if (txt_load) begin
          rd_pend_d = 1'b0;
        end
      end
      PH_END: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = KIND_END;
          num_d   = '0;
          char_d  = '0;
          idx_d   = '0;
          len_d   = '0;
          last_d  = 1'b1;
          phase_d = PH_READY;
        end
      end
      default: begin
        phase_d = PH_READY;
      end
    endcase

    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= LEX_IDLE;
      accum_q     <= '0;
      digits_q    <= '0;
      count_q     <= '0;
      latched_q   <= 1'b0;
      phase_q     <= PH_READY;
      rd_idx_q    <= '0;
      ld_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q    <= mode_d;
        accum_q   <= accum_d;
        digits_q  <= digits_d;
        count_q   <= count_d;
        latched_q <= latched_d;
      end
      phase_q     <= phase_d;
      rd_idx_q    <= rd_idx_d;
      ld_idx_q    <= ld_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pending result plan, captured with the item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      num_pend_q <= p_numval;
      len_pend_q <= p_len;
      end_pend_q <= p_end;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      num_q  <= num_d;
      char_q <= char_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = kind_q;
  assign number_value_o = num_q;
  assign text_char_o    = char_q;
  assign text_index_o   = idx_q;
  assign text_length_o  = len_q;
  assign last_o         = last_q;

endmodule

// ===== bench/tb_top.sv =====
module tb_top import stl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PRINT_LIMIT    = 20;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NUM_W-1:0]  num;
    logic [CHAR_W-1:0] ch;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  len;
    logic              last;
  } token_t;

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              in_valid_i         = 1'b0;
  logic              in_stall_o;
  logic [CHAR_W-1:0] char_byte_i        = '0;
  logic              single_char_mode_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i        = 1'b0;
  logic [KIND_W-1:0] token_kind_o;
  logic [NUM_W-1:0]  number_value_o;
  logic [CHAR_W-1:0] text_char_o;
  logic [CNT_W-1:0]  text_index_o;
  logic [CNT_W-1:0]  text_length_o;
  logic              last_o;

  script_token_lexer i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .char_byte_i        (char_byte_i),
    .single_char_mode_i (single_char_mode_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .token_kind_o       (token_kind_o),
    .number_value_o     (number_value_o),
    .text_char_o        (text_char_o),
    .text_index_o       (text_index_o),
    .text_length_o      (text_length_o),
    .last_o             (last_o)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // expected tokens and run counters
  token_t tokens_expected[$];
  int     err_cnt        = 0;
  int     bytes_sent     = 0;
  int     tokens_checked = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     hold_req_cnt   = 0;

  // lexer state mirror
  lex_mode_e         mode_q   = LEX_IDLE;
  logic [NUM_W-1:0]  num_acc  = '0;
  logic [DIG_W-1:0]  dig_cnt  = '0;
  logic [CHAR_W-1:0] txt_buf [MAX_TEXT];
  logic [CNT_W-1:0]  txt_cnt  = '0;
  logic              char_lat = 1'b0;

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void push_token(logic [KIND_W-1:0] kind, logic [NUM_W-1:0] num,
                                     logic [CHAR_W-1:0] ch, logic [CNT_W-1:0] idx,
                                     logic [CNT_W-1:0] len, logic last);
    token_t t;
    t.kind = kind;
    t.num  = num;
    t.ch   = ch;
    t.idx  = idx;
    t.len  = len;
    t.last = last;
    tokens_expected.push_back(t);
  endfunction

  function automatic void flush_number();
    push_token(KIND_NUMBER, num_acc, '0, '0, '0, 1'b1);
    num_acc = '0;
    dig_cnt = '0;
    mode_q  = LEX_IDLE;
  endfunction

  function automatic void flush_text();
    for (int i = 0; i < txt_cnt; i++) begin
      push_token(KIND_TEXT, '0, txt_buf[i], CNT_W'(i), txt_cnt, (i + 1 == txt_cnt));
    end
    txt_cnt = '0;
    mode_q  = LEX_IDLE;
  endfunction

  // byte seen while between tokens
  function automatic void between_tokens(logic [CHAR_W-1:0] c, logic sc);
    mode_q = LEX_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_COMMA || c == CH_LF) begin
      return;
    end else if (c == CH_CR) begin
      mode_q = LEX_SKIP;
    end else if (c == CH_HASH) begin
      mode_q = LEX_COMMENT;
    end else if (c == CH_NUL) begin
      push_token(KIND_END, '0, '0, '0, '0, 1'b1);
    end else if (is_digit(c)) begin
      num_acc = NUM_W'(c - CH_ZERO);
      dig_cnt = DIG_W'(1);
      mode_q  = LEX_NUMBER;
    end else begin
      txt_buf[0] = c;
      txt_cnt    = CNT_W'(1);
      char_lat   = sc;
      if (sc || txt_cnt >= TEXT_LIMIT) flush_text();
      else mode_q = LEX_TEXT;
    end
  endfunction

  // expected tokens caused by one accepted byte
  function automatic void lex_byte(logic [CHAR_W-1:0] c, logic sc);
    case (mode_q)
      LEX_SKIP: begin
        mode_q = LEX_IDLE;
        if (c == CH_NUL) push_token(KIND_END, '0, '0, '0, '0, 1'b1);
      end
      LEX_COMMENT: begin
        if (c == CH_NUL) begin
          mode_q = LEX_IDLE;
          push_token(KIND_END, '0, '0, '0, '0, 1'b1);
        end else if (c == CH_CR) begin
          mode_q = LEX_SKIP;
        end else if (c == CH_LF) begin
          mode_q = LEX_IDLE;
        end
      end
      LEX_NUMBER: begin
        if (is_digit(c)) begin
          num_acc = NUM_W'(num_acc * 10 + (c - CH_ZERO));
          dig_cnt = dig_cnt + 1'b1;
          if (dig_cnt >= MAX_DIGITS) flush_number();
        end else begin
          flush_number();
          between_tokens(c, sc);
        end
      end
      LEX_TEXT: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_NUL) begin
          flush_text();
          between_tokens(c, sc);
        end else begin
          if (txt_cnt < TEXT_DEPTH) begin
            txt_buf[txt_cnt] = c;
            txt_cnt          = txt_cnt + 1'b1;
          end
          if (txt_cnt >= TEXT_LIMIT || char_lat) flush_text();
        end
      end
      default: between_tokens(c, sc);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_cnt < PRINT_LIMIT) begin
      $display("%0t mismatch %s: got %0d expected %0d (token %0d)",
               $realtime, what, got, want, tokens_checked);
    end
    err_cnt++;
  endtask

  // receiver: check each token, drive stall
  always @(posedge clk_i) begin : receiver
    token_t want;
    int     hold_seen;
    int     hold_left;
    if (out_valid_o && !out_stall_i) begin
      if (tokens_expected.size() == 0) begin
        report_mismatch("token with none expected, kind", token_kind_o, 0);
      end else begin
        want = tokens_expected.pop_front();
        if (token_kind_o !== want.kind) report_mismatch("kind", token_kind_o, want.kind);
        if (number_value_o !== want.num) report_mismatch("number", number_value_o, want.num);
        if (text_char_o !== want.ch) report_mismatch("char", text_char_o, want.ch);
        if (text_index_o !== want.idx) report_mismatch("index", text_index_o, want.idx);
        if (text_length_o !== want.len) report_mismatch("length", text_length_o, want.len);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
      tokens_checked++;
    end
    // long hold-off when asked, else random stall
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // send one byte, with a random gap before it
  task automatic send_char(logic [CHAR_W-1:0] c, logic sc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i         <= 1'b1;
    char_byte_i        <= c;
    single_char_mode_i <= sc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lex_byte(c, sc);
    bytes_sent++;
  endtask

  task automatic send_text(string s, logic sc);
    for (int i = 0; i < s.len(); i++) send_char(s[i], sc);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // random text character; a lead one must start a text token
  function automatic logic [CHAR_W-1:0] pick_text_char(logic lead);
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(1, 255));
    end while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
               (lead && (is_digit(c) || c == CH_HASH || c == CH_COMMA)));
    return c;
  endfunction

  task automatic send_word(int len);
    send_char(pick_text_char(1'b1), ($urandom_range(99) < 15));
    for (int i = 1; i < len; i++) send_char(pick_text_char(1'b0), 1'($urandom_range(1)));
  endtask

  // script-like stream: words, numbers, separators, comments, ends, noise
  task automatic send_script(int n_bytes);
    int start;
    int pick;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 8);
        send_word(len);
      end else if (pick < 55) begin
        len = $urandom_range(1, 7);
        repeat (len) send_char(CH_ZERO + CHAR_W'($urandom_range(9)), 1'($urandom_range(1)));
      end else if (pick < 75) begin
        case ($urandom_range(4))
          0: send_char(CH_SPACE, 1'($urandom_range(1)));
          1: send_char(CH_TAB, 1'($urandom_range(1)));
          2: send_char(CH_COMMA, 1'($urandom_range(1)));
          3: send_char(CH_LF, 1'($urandom_range(1)));
          default: begin
            send_char(CH_CR, 1'($urandom_range(1)));
            if ($urandom_range(3) != 0) send_char(CH_LF, 1'b0);
            else send_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
            bytes_sent--;
          end
        endcase
      end else if (pick < 83) begin
        send_char(CH_HASH, 1'($urandom_range(1)));
        len = $urandom_range(6);
        // comment body is skipped by the block and not counted
        repeat (len) begin
          send_char(pick_text_char(1'b0), 1'($urandom_range(1)));
          bytes_sent--;
        end
        case ($urandom_range(2))
          0: send_char(CH_LF, 1'b0);
          1: begin
            send_char(CH_CR, 1'b0);
            send_char(CH_LF, 1'b0);
            bytes_sent--;
          end
          default: send_char(CH_NUL, 1'b0);
        endcase
      end else if (pick < 90) begin
        send_char(CH_NUL, 1'($urandom_range(1)));
      end else begin
        send_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  // directed cases
  task automatic test_directed();
    set_idling(0, 0);
    send_text(" \t,\n", 1'b1);
    // byte after cr is skipped
    send_char(CH_CR, 1'b0);
    send_char("Q", 1'b1);
    // five digits close a number at once
    send_text("99999", 1'b0);
    // number closed by text; comma, hash, digit kept inside text
    send_text("7a,#9 ", 1'b0);
    // single-character text token
    send_char("Z", 1'b1);
    // high bytes as text, closed by tab
    send_char(8'hff, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(CH_TAB, 1'b0);
    // zero right after cr
    send_char(CH_CR, 1'b0);
    send_char(CH_NUL, 1'b0);
    // zero inside a comment, then a repeated zero
    send_char(CH_HASH, 1'b0);
    send_char(CH_NUL, 1'b1);
    send_char(CH_NUL, 1'b0);
  endtask

  task automatic test_no_idle();
    set_idling(0, 0);
    send_script(80);
  endtask

  task automatic test_sender_idle();
    set_idling(80, 0);
    send_script(80);
  endtask

  task automatic test_receiver_stall();
    set_idling(0, 80);
    send_script(80);
  endtask

  task automatic test_both_idle();
    set_idling(17, 17);
    send_script(80);
  endtask

  // receiver holds off while long texts closed by zero keep coming
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_req_cnt++;
    repeat (2) begin
      send_word(30);
      send_char(CH_NUL, 1'b0);
    end
  endtask

  // text reaching the buffer limit, remainder starts a new token
  task automatic test_text_limit();
    set_idling(17, 17);
    send_word(40);
    send_char(CH_SPACE, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_text_limit();
    in_valid_i <= 1'b0;
    while (tokens_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("lexed %0d bytes into %0d checked tokens", bytes_sent, tokens_checked);
    $display("idle and stall phases, long hold-off and text limit included");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== script_token_lexer.f =====
rtl/core/stl_pkg.sv
rtl/core/stl_ram.sv
rtl/core/script_token_lexer.sv
bench/tb_top.sv
